FILE: design/rpfa_pkg.sv
// ----------------------------------------------------------------------------
// rpfa_pkg
// constants, command codes and status codes of the page frame allocator
// ----------------------------------------------------------------------------
package rpfa_pkg;

  // table geometry
  localparam int unsigned MAX_FRAMES = 4096;
  localparam int unsigned FRAME_SHIFT = 12;
  localparam int unsigned IDX_W      = $clog2(MAX_FRAMES);
  localparam int unsigned CNT_W      = IDX_W + 1;       // holds MAX_FRAMES itself
  localparam int unsigned FC_W       = 13;              // frame_count register
  localparam int unsigned PG_W       = 33 - FRAME_SHIFT; // rounded-up page count
  localparam int unsigned LIMF_W     = 32 - FRAME_SHIFT; // limit in frames
  localparam int unsigned EW         = PG_W + 2;        // signed run end math

  // frame byte layout
  localparam logic [7:0] BYTE_FREE     = 8'h00;
  localparam logic [7:0] BYTE_ONE_USER = 8'h01;
  localparam logic [6:0] CNT_RESERVED  = 7'd127;
  localparam logic [6:0] CNT_ADD_MAX   = 7'd126;

  // commands
  localparam logic [2:0] CMD_ALLOC    = 3'd0;
  localparam logic [2:0] CMD_CONTIG   = 3'd1;
  localparam logic [2:0] CMD_FREE     = 3'd2;
  localparam logic [2:0] CMD_ADD_USER = 3'd3;
  localparam logic [2:0] CMD_RESERVE  = 3'd4;
  localparam logic [2:0] CMD_SET_COW  = 3'd5;
  localparam logic [2:0] CMD_QUERY    = 3'd6;
  localparam logic [2:0] CMD_INVALID  = 3'd7;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FREE  = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_BAD_CNT  = 2'd3;

  // configuration register indexes
  localparam logic CFG_MEMORY_BASE = 1'b0;
  localparam logic CFG_FRAME_COUNT = 1'b1;

  localparam logic [FC_W-1:0] FRAME_COUNT_RST = FC_W'(MAX_FRAMES);

endpackage

FILE: design/refcounted_page_frame_allocator.sv
// ----------------------------------------------------------------------------
// refcounted_page_frame_allocator
// reference counted page frame table with single and contiguous allocation
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       sink       in_valid_i/in_stall_o  command, page_address, cow_value,
//                                             length_bytes, address_limit,
//                                             align_log2
//  out      source     out_valid_o/out_stall_i status, granted_address,
//                                             user_count, cow_bit, is_allocated
//  cfg      sink       cfg_we_i               cfg_index_i, cfg_wdata_i
//
//  free, add_user, reserve, set_cow, query: table read, then
//    read-modify-write through the table port, held while the output is full
//  alloc: frames read one at a time from the search hint until a free frame
//    is found and written; a failed search ends in the result state
//  alloc_contig: a bound check, then for each start considered an alignment
//    check (with a closing bound check when the search fails), a read of each
//    frame of the run and a return to the next start after a busy frame; then each frame is written
//  after reset the table is swept to zero, one frame a cycle, with the input
//    stalled; results wait in the output register
// ----------------------------------------------------------------------------
module refcounted_page_frame_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  // command words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [31:0] page_address_i,
  input  logic        cow_value_i,
  input  logic [31:0] length_bytes_i,
  input  logic [31:0] address_limit_i,
  input  logic [4:0]  align_log2_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] granted_address_o,
  output logic [6:0]  user_count_o,
  output logic        cow_bit_o,
  output logic        is_allocated_o
);
  import rpfa_pkg::*;

  // sequencer states
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_RMW    = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_CSET   = 4'd4;
  localparam logic [3:0] S_CALIGN = 4'd5;
  localparam logic [3:0] S_CSCAN  = 4'd6;
  localparam logic [3:0] S_CFILL  = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;

  // frame table, one byte per frame
  logic [7:0]       mem [MAX_FRAMES];
  logic [7:0]       rdata_q;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]       mem_wdata;

  // control state
  logic [3:0]       state_q, state_d;
  logic [IDX_W-1:0] clr_q, clr_d;
  logic [CNT_W-1:0] hint_q, hint_d;
  logic [CNT_W-1:0] cur_q, cur_d;     // next frame to read or write
  logic [CNT_W-1:0] chk_q, chk_d;     // frame whose byte sits in rdata_q
  logic             pend_q, pend_d;   // rdata_q holds a scan read
  logic [CNT_W-1:0] end_q, end_d;     // scan or candidate bound
  logic [CNT_W-1:0] cand_q, cand_d;   // contiguous run candidate
  logic [CNT_W-1:0] runend_q, runend_d;
  logic [1:0]       fail_q, fail_d;
  logic             out_valid_q;
  logic [31:0]      memory_base_q;
  logic [FC_W-1:0]  frame_count_q;

  // command payload held for the sequencer
  logic [2:0]       cmd_q;
  logic             cowv_q;
  logic [4:0]       align_q;
  logic [PG_W-1:0]  pages_q;
  logic [LIMF_W-1:0] limf_q;
  logic [IDX_W-1:0] idx_q;

  // output register
  logic [1:0]       status_q;
  logic [31:0]      addr_q;
  logic [7:0]       byte_q;

  // datapath
  logic             accept, out_free, ld_out;
  logic [1:0]       ld_status;
  logic [31:0]      ld_addr;
  logic [7:0]       ld_byte;
  logic [CNT_W-1:0] n_frames;
  logic [31:0]      pa_off;
  logic             pa_bad;
  logic [32:0]      len_sum;
  logic [7:0]       nb;
  logic [6:0]       cnt;
  logic signed [EW-1:0] e_lim, e_fit, e_end;
  logic [31:0]      cand_addr, amask;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // managed frames, frame_count clipped at the table size
  assign n_frames = (CNT_W'(frame_count_q) > CNT_W'(MAX_FRAMES)) ?
                    CNT_W'(MAX_FRAMES) : CNT_W'(frame_count_q);

  // single frame address decode
  assign pa_off  = page_address_i - memory_base_q;
  assign pa_bad  = (page_address_i[FRAME_SHIFT-1:0] != '0) ||
                   ({{(FRAME_SHIFT){1'b0}}, pa_off[31:FRAME_SHIFT]} >= 32'(n_frames));
  assign len_sum = {1'b0, length_bytes_i} + 33'((33'd1 << FRAME_SHIFT) - 33'd1);

  // run bound: below the limit and inside the managed frames
  assign e_lim = $signed(EW'(limf_q)) - $signed(EW'(pages_q));
  assign e_fit = $signed(EW'(n_frames)) - $signed(EW'(pages_q)) + $signed(EW'(1));
  assign e_end = (e_lim > e_fit) ? e_fit : e_lim;

  assign cand_addr = memory_base_q + (32'(cand_q) << FRAME_SHIFT);
  assign amask     = (32'd1 << align_q) - 32'd1;

  assign cnt = rdata_q[6:0];

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    hint_d    = hint_q;
    cur_d     = cur_q;
    chk_d     = chk_q;
    pend_d    = pend_q;
    end_d     = end_q;
    cand_d    = cand_q;
    runend_d  = runend_q;
    fail_d    = fail_q;
    mem_we    = 1'b0;
    mem_waddr = cur_q[IDX_W-1:0];
    mem_wdata = BYTE_ONE_USER;
    mem_re    = 1'b0;
    mem_raddr = cur_q[IDX_W-1:0];
    ld_out    = 1'b0;
    ld_status = ST_OK;
    ld_addr   = '0;
    ld_byte   = BYTE_FREE;
    nb        = rdata_q;

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = BYTE_FREE;
        clr_d     = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(MAX_FRAMES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (command_i)
            CMD_ALLOC: begin
              cur_d   = hint_q;
              end_d   = n_frames;
              pend_d  = 1'b0;
              state_d = S_SCAN;
            end
            CMD_CONTIG: begin
              if (length_bytes_i == '0) begin
                fail_d  = ST_NO_FREE;
                state_d = S_FIN;
              end else begin
                state_d = S_CSET;
              end
            end
            CMD_INVALID: begin
              fail_d  = ST_RANGE;
              state_d = S_FIN;
            end
            default: begin
              if (pa_bad) begin
                fail_d  = ST_RANGE;
                state_d = S_FIN;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = pa_off[FRAME_SHIFT +: IDX_W];
                state_d   = S_RMW;
              end
            end
          endcase
        end
      end
      S_RMW: begin
        ld_status = ST_OK;
        case (cmd_q)
          CMD_FREE: begin
            if (cnt == '0) begin
              ld_status = ST_BAD_CNT;
            end else begin
              nb = rdata_q - 8'd1;
            end
          end
          CMD_ADD_USER: begin
            if (cnt == '0 || cnt >= CNT_ADD_MAX) begin
              ld_status = ST_BAD_CNT;
            end else begin
              nb = rdata_q + 8'd1;
            end
          end
          CMD_RESERVE: nb = {1'b0, CNT_RESERVED};
          CMD_SET_COW: begin
            if (cnt == '0) begin
              ld_status = ST_BAD_CNT;
            end else begin
              nb = {cowv_q, cnt};
            end
          end
          default: nb = rdata_q;
        endcase
        ld_byte = nb;
        if (out_free) begin
          ld_out    = 1'b1;
          mem_we    = (ld_status == ST_OK) && (cmd_q != CMD_QUERY);
          mem_waddr = idx_q;
          mem_wdata = nb;
          // freeing the last user pulls the hint down
          if (cmd_q == CMD_FREE && ld_status == ST_OK && nb == BYTE_FREE &&
              hint_q > CNT_W'(idx_q)) begin
            hint_d = CNT_W'(idx_q);
          end
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        if (pend_q && rdata_q == BYTE_FREE) begin
          ld_status = ST_OK;
          ld_addr   = memory_base_q + (32'(chk_q) << FRAME_SHIFT);
          ld_byte   = BYTE_ONE_USER;
          if (out_free) begin
            ld_out    = 1'b1;
            mem_we    = 1'b1;
            mem_waddr = chk_q[IDX_W-1:0];
            hint_d    = chk_q;
            state_d   = S_IDLE;
          end
        end else if (cur_q < end_q) begin
          mem_re = 1'b1;
          chk_d  = cur_q;
          cur_d  = cur_q + CNT_W'(1);
          pend_d = 1'b1;
        end else begin
          fail_d  = ST_NO_FREE;
          state_d = S_FIN;
        end
      end
      S_CSET: begin
        if (e_end <= $signed(EW'(hint_q))) begin
          fail_d  = ST_NO_FREE;
          state_d = S_FIN;
        end else begin
          end_d   = e_end[CNT_W-1:0];
          cand_d  = hint_q;
          state_d = S_CALIGN;
        end
      end
      S_CALIGN: begin
        if (cand_q >= end_q) begin
          fail_d  = ST_NO_FREE;
          state_d = S_FIN;
        end else if ((cand_addr & amask) != '0) begin
          cand_d = cand_q + CNT_W'(1);
        end else begin
          cur_d    = cand_q;
          runend_d = cand_q + pages_q[CNT_W-1:0];
          pend_d   = 1'b0;
          state_d  = S_CSCAN;
        end
      end
      S_CSCAN: begin
        if (pend_q && rdata_q != BYTE_FREE) begin
          // every candidate up to the busy frame overlaps it
          cand_d  = chk_q + CNT_W'(1);
          pend_d  = 1'b0;
          state_d = S_CALIGN;
        end else if (cur_q < runend_q) begin
          mem_re = 1'b1;
          chk_d  = cur_q;
          cur_d  = cur_q + CNT_W'(1);
          pend_d = 1'b1;
        end else begin
          cur_d   = cand_q;
          pend_d  = 1'b0;
          state_d = S_CFILL;
        end
      end
      S_CFILL: begin
        if (cur_q < runend_q) begin
          mem_we = 1'b1;
          cur_d  = cur_q + CNT_W'(1);
        end else begin
          ld_status = ST_OK;
          ld_addr   = cand_addr;
          ld_byte   = BYTE_ONE_USER;
          if (out_free) begin
            ld_out  = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      S_FIN: begin
        ld_status = fail_q;
        if (out_free) begin
          ld_out  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // table port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      clr_q         <= '0;
      hint_q        <= '0;
      cur_q         <= '0;
      chk_q         <= '0;
      pend_q        <= 1'b0;
      end_q         <= '0;
      cand_q        <= '0;
      runend_q      <= '0;
      fail_q        <= ST_OK;
      out_valid_q   <= 1'b0;
      memory_base_q <= '0;
      frame_count_q <= FRAME_COUNT_RST;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      hint_q   <= hint_d;
      cur_q    <= cur_d;
      chk_q    <= chk_d;
      pend_q   <= pend_d;
      end_q    <= end_d;
      cand_q   <= cand_d;
      runend_q <= runend_d;
      fail_q   <= fail_d;
      if (ld_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_MEMORY_BASE: memory_base_q <= cfg_wdata_i;
          CFG_FRAME_COUNT: frame_count_q <= cfg_wdata_i[FC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= command_i;
      cowv_q  <= cow_value_i;
      align_q <= align_log2_i;
      pages_q <= len_sum[32:FRAME_SHIFT];
      limf_q  <= address_limit_i[31:FRAME_SHIFT];
      idx_q   <= pa_off[FRAME_SHIFT +: IDX_W];
    end
    if (ld_out) begin
      status_q <= ld_status;
      addr_q   <= ld_addr;
      byte_q   <= ld_byte;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign granted_address_o = addr_q;
  assign user_count_o      = byte_q[6:0];
  assign cow_bit_o         = byte_q[7];
  assign is_allocated_o    = (byte_q[6:0] != '0) && (byte_q[6:0] != CNT_RESERVED);

  // checks on the sequencer
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !mem_we)
    else $error("table written while idle");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_out |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a waiting word");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_CSCAN) && pend_q |-> chk_q < n_frames)
    else $error("scan read beyond managed frames");

  a_run_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CFILL |-> runend_q <= n_frames)
    else $error("contiguous run beyond managed frames");

  a_hint_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hint_q < CNT_W'(MAX_FRAMES))
    else $error("search hint out of range");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) != S_IDLE && $past(state_q) != S_CLEAR)
    else $error("result without a command");

endmodule

FILE: test/rpfa_frame_checker.sv
// ----------------------------------------------------------------------------
// rpfa_frame_checker
// watches the command and result channels of the page frame allocator,
// predicts every result word from its own copy of the frame table and
// compares the words field by field, in order
// ----------------------------------------------------------------------------
module rpfa_frame_checker
  import rpfa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  command_i,
  input  logic [31:0] page_address_i,
  input  logic        cow_value_i,
  input  logic [31:0] length_bytes_i,
  input  logic [31:0] address_limit_i,
  input  logic [4:0]  align_log2_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  status_i,
  input  logic [31:0] granted_address_i,
  input  logic [6:0]  user_count_i,
  input  logic        cow_bit_i,
  input  logic        is_allocated_i,
  output int          mismatch_count_o,
  output int          pending_o
);

  localparam longint PAGE_MASK = (64'd1 << FRAME_SHIFT) - 64'd1;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] address;
    logic [6:0]  count;
    logic        cow;
    logic        in_use;
  } frame_result_t;

  logic [7:0]      frames [MAX_FRAMES];
  longint          hint;
  logic [31:0]     base;
  logic [FC_W-1:0] frame_count;
  frame_result_t   awaited_results [$];

  // byte of one frame as the result word reports it
  function automatic frame_result_t frame_view(logic [1:0] st, logic [31:0] addr, longint idx);
    frame_result_t r;
    logic [7:0]    b;
    b         = frames[idx];
    r.status  = st;
    r.address = addr;
    r.count   = b[6:0];
    r.cow     = b[7];
    r.in_use  = (b[6:0] != 7'd0) && (b[6:0] != CNT_RESERVED);
    return r;
  endfunction

  // applies one command word to the frame table and returns its result word
  function automatic frame_result_t frame_op_outcome(logic [2:0] cmd, logic [31:0] pa,
                                                    logic cowv, logic [31:0] len,
                                                    logic [31:0] lim, logic [4:0] align);
    frame_result_t r;
    longint        n, pages, run_end, i, j, idx;
    logic [31:0]   fa, offset;
    logic [63:0]   amask;
    logic [7:0]    b;
    logic [1:0]    st;
    bit            hit, ok;
    r   = '0;
    hit = 1'b0;
    n   = (frame_count > MAX_FRAMES) ? longint'(MAX_FRAMES) : longint'(frame_count);
    case (cmd)
      CMD_ALLOC: begin
        r.status = ST_NO_FREE;
        for (i = hint; i < n && !hit; i++) begin
          if (frames[i] == BYTE_FREE) begin
            frames[i] = BYTE_ONE_USER;
            hint      = i;
            r         = frame_view(ST_OK, base + 32'(i << FRAME_SHIFT), i);
            hit       = 1'b1;
          end
        end
      end
      CMD_CONTIG: begin
        r.status = ST_NO_FREE;
        if (len != 32'd0) begin
          pages   = (longint'(len) + PAGE_MASK) >> FRAME_SHIFT;
          run_end = longint'(lim >> FRAME_SHIFT) - pages;
          if (run_end > n - pages + 1) run_end = n - pages + 1;
          amask = (64'd1 << align) - 64'd1;
          for (i = hint; i < run_end && !hit; i++) begin
            fa = base + 32'(i << FRAME_SHIFT);
            if ((64'(fa) & amask) == 64'd0) begin
              ok = 1'b1;
              for (j = 0; j < pages && ok; j++) begin
                if (frames[i + j] != BYTE_FREE) ok = 1'b0;
              end
              if (ok) begin
                for (j = 0; j < pages; j++) frames[i + j] = BYTE_ONE_USER;
                r   = frame_view(ST_OK, fa, i);
                hit = 1'b1;
              end
            end
          end
        end
      end
      CMD_INVALID: r.status = ST_RANGE;
      default: begin
        offset = pa - base;
        idx    = longint'(offset >> FRAME_SHIFT);
        if (pa[FRAME_SHIFT-1:0] != '0 || idx >= n) begin
          r.status = ST_RANGE;
        end else begin
          b  = frames[idx];
          st = ST_OK;
          case (cmd)
            CMD_FREE: begin
              if (b[6:0] == 7'd0) begin
                st = ST_BAD_CNT;
              end else begin
                frames[idx] = b - 8'd1;
                if (frames[idx] == BYTE_FREE && hint > idx) hint = idx;
              end
            end
            CMD_ADD_USER: begin
              if (b[6:0] == 7'd0 || b[6:0] >= CNT_ADD_MAX) st = ST_BAD_CNT;
              else frames[idx] = b + 8'd1;
            end
            CMD_RESERVE: frames[idx] = {1'b0, CNT_RESERVED};
            CMD_SET_COW: begin
              if (b[6:0] == 7'd0) st = ST_BAD_CNT;
              else frames[idx] = {cowv, b[6:0]};
            end
            default: ;
          endcase
          r = frame_view(st, 32'd0, idx);
        end
      end
    endcase
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t want;
    if (!rst_ni) begin
      foreach (frames[k]) frames[k] = BYTE_FREE;
      hint        = 0;
      base        = '0;
      frame_count = FRAME_COUNT_RST;
      awaited_results.delete();
      pending_o        = 0;
      mismatch_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_MEMORY_BASE) base = cfg_wdata_i;
        else frame_count = cfg_wdata_i[FC_W-1:0];
      end
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $error("result word with nothing awaited: status 0x%0h", status_i);
          mismatch_count_o++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", 32'(want.status), 32'(status_i));
          check_field("granted_address", want.address, granted_address_i);
          check_field("user_count", 32'(want.count), 32'(user_count_i));
          check_field("cow_bit", 32'(want.cow), 32'(cow_bit_i));
          check_field("is_allocated", 32'(want.in_use), 32'(is_allocated_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_results.push_back(frame_op_outcome(command_i, page_address_i, cow_value_i,
                                                   length_bytes_i, address_limit_i,
                                                   align_log2_i));
      end
      pending_o = awaited_results.size();
    end
  end

endmodule

FILE: test/refcounted_page_frame_allocator_tb.sv
// ----------------------------------------------------------------------------
// refcounted_page_frame_allocator_tb
// drives command words into the page frame allocator under shifting memory
// base and frame count settings, with random idling on both channels and
// long receiver hold-offs; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module refcounted_page_frame_allocator_tb;
  import rpfa_pkg::*;

  localparam int HOLD_CYCLES   = 400;  // long receiver hold-off
  localparam int SETTLE_CYCLES = 16;   // quiet cycles after the last result word
  localparam int PAGE          = 1 << FRAME_SHIFT;

  // block inputs, all known from time zero
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic        cfg_index_i     = CFG_MEMORY_BASE;
  logic [31:0] cfg_wdata_i     = '0;
  logic        in_valid_i      = 1'b0;
  logic [2:0]  command_i       = CMD_QUERY;
  logic [31:0] page_address_i  = '0;
  logic        cow_value_i     = 1'b0;
  logic [31:0] length_bytes_i  = '0;
  logic [31:0] address_limit_i = '0;
  logic [4:0]  align_log2_i    = '0;
  logic        out_stall_i     = 1'b0;

  // block outputs
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  status_o;
  logic [31:0] granted_address_o;
  logic [6:0]  user_count_o;
  logic        cow_bit_o;
  logic        is_allocated_o;

  int mismatch_count;
  int pending;

  // stimulus knobs shared between the sender and the receiver process
  int          send_idle_pct = 19;
  int          recv_idle_pct = 56;
  bit          hold_req      = 1'b0;
  logic [31:0] cur_base      = '0;
  int          cur_frames    = MAX_FRAMES;

  refcounted_page_frame_allocator dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .page_address_i   (page_address_i),
    .cow_value_i      (cow_value_i),
    .length_bytes_i   (length_bytes_i),
    .address_limit_i  (address_limit_i),
    .align_log2_i     (align_log2_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .granted_address_o(granted_address_o),
    .user_count_o     (user_count_o),
    .cow_bit_o        (cow_bit_o),
    .is_allocated_o   (is_allocated_o)
  );

  rpfa_frame_checker frame_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .command_i        (command_i),
    .page_address_i   (page_address_i),
    .cow_value_i      (cow_value_i),
    .length_bytes_i   (length_bytes_i),
    .address_limit_i  (address_limit_i),
    .align_log2_i     (align_log2_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_i         (status_o),
    .granted_address_i(granted_address_o),
    .user_count_i     (user_count_o),
    .cow_bit_i        (cow_bit_o),
    .is_allocated_i   (is_allocated_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run limit, far above the slowest legal run (full table scans included)
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: random stall per cycle, or a long hold-off when asked for
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        // block fills up behind the held result and stalls its input
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_stall_i = ($urandom_range(99) < recv_idle_pct);
    end
  end

  // address of frame idx under the current memory base
  function automatic logic [31:0] frame_at(int idx);
    return cur_base + (32'(idx) << FRAME_SHIFT);
  endfunction

  // mostly frames in range, some just past the end, misaligned or anything
  function automatic logic [31:0] pick_address();
    int r;
    r = $urandom_range(99);
    if (r < 75 && cur_frames > 0) return frame_at($urandom_range(cur_frames - 1));
    if (r < 85) return frame_at(cur_frames + $urandom_range(3));
    if (r < 93) return frame_at($urandom_range(cur_frames)) + 32'($urandom_range(PAGE - 1, 1));
    return $urandom;
  endfunction

  // one command word; entered and left at a falling edge, valid left high
  task automatic send_word(logic [2:0] cmd, logic [31:0] pa, logic cowv,
                           logic [31:0] len, logic [31:0] lim, logic [4:0] align);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    command_i       = cmd;
    page_address_i  = pa;
    cow_value_i     = cowv;
    length_bytes_i  = len;
    address_limit_i = lim;
    align_log2_i    = align;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // single frame commands carry random filler in the contiguous fields
  task automatic frame_cmd(logic [2:0] cmd, logic [31:0] pa, logic cowv);
    send_word(cmd, pa, cowv, $urandom, $urandom, 5'($urandom));
  endtask

  task automatic contig_cmd(logic [31:0] len, logic [31:0] lim, logic [4:0] align);
    send_word(CMD_CONTIG, $urandom, 1'($urandom), len, lim, align);
  endtask

  // wait until every result word is back and the block has gone quiet
  task automatic drain_results();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  task automatic reconfigure(logic [31:0] base, int fc);
    drain_results();
    write_reg(CFG_MEMORY_BASE, base);
    write_reg(CFG_FRAME_COUNT, 32'(fc));
    cur_base   = base;
    cur_frames = (fc > MAX_FRAMES) ? MAX_FRAMES : fc;
  endtask

  task automatic send_random_word();
    int          r;
    logic [31:0] len, lim;
    logic [4:0]  align;
    r = $urandom_range(99);
    if (r < 25) begin
      frame_cmd(CMD_ALLOC, $urandom, 1'($urandom));
    end else if (r < 37) begin
      // small runs mostly, now and then empty or absurdly long
      r = $urandom_range(99);
      if (r < 5) len = '0;
      else if (r < 85) len = $urandom_range(4 * PAGE, 1);
      else if (r < 95) len = 32'($urandom_range(16, 1)) << FRAME_SHIFT;
      else len = $urandom;
      r = $urandom_range(99);
      if (r < 60) lim = '1;
      else if (r < 90) lim = (32'($urandom_range(cur_frames + 8)) << FRAME_SHIFT)
                             + 32'($urandom_range(PAGE - 1));
      else lim = $urandom;
      r = $urandom_range(99);
      if (r < 60) align = 5'($urandom_range(13));
      else if (r < 95) align = 5'($urandom_range(16, 13));
      else align = 5'($urandom_range(31, 17));
      contig_cmd(len, lim, align);
    end else if (r < 57) begin
      frame_cmd(CMD_FREE, pick_address(), 1'($urandom));
    end else if (r < 67) begin
      frame_cmd(CMD_ADD_USER, pick_address(), 1'($urandom));
    end else if (r < 71) begin
      frame_cmd(CMD_RESERVE, pick_address(), 1'($urandom));
    end else if (r < 81) begin
      frame_cmd(CMD_SET_COW, pick_address(), 1'($urandom));
    end else if (r < 95) begin
      frame_cmd(CMD_QUERY, pick_address(), 1'($urandom));
    end else begin
      frame_cmd(CMD_INVALID, pick_address(), 1'($urandom));
    end
  endtask

  // one setting of the registers and a stream of random words under it;
  // a squeezed phase gets a receiver hold-off and a full sender pause
  task automatic run_phase(logic [31:0] base, int fc, int items,
                           int send_pct, int recv_pct, bit squeeze);
    reconfigure(base, fc);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int k = 0; k < items; k++) begin
      if (squeeze && k == items / 3) hold_req = 1'b1;
      if (squeeze && k == 2 * items / 3) drain_results();
      send_random_word();
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed words under the reset settings: base 0, full table;
    // the first word waits out the clearing sweep
    frame_cmd(CMD_QUERY, frame_at(0), 1'b0);
    frame_cmd(CMD_FREE, frame_at(0), 1'b0);         // count zero
    frame_cmd(CMD_ADD_USER, frame_at(0), 1'b0);     // count zero
    frame_cmd(CMD_SET_COW, frame_at(0), 1'b1);      // count zero
    frame_cmd(CMD_ALLOC, '1, 1'b1);                 // frame 0
    frame_cmd(CMD_ALLOC, '0, 1'b0);                 // frame 1
    frame_cmd(CMD_ADD_USER, frame_at(0), 1'b0);
    frame_cmd(CMD_SET_COW, frame_at(0), 1'b1);
    frame_cmd(CMD_FREE, frame_at(0), 1'b0);
    frame_cmd(CMD_FREE, frame_at(0), 1'b0);         // count zero, cow kept: not free
    frame_cmd(CMD_ALLOC, '0, 1'b0);                 // skips frames 0 and 1
    frame_cmd(CMD_FREE, frame_at(1), 1'b0);         // pulls the hint down
    frame_cmd(CMD_ALLOC, '0, 1'b0);                 // gets frame 1 back
    frame_cmd(CMD_RESERVE, frame_at(5), 1'b0);
    frame_cmd(CMD_ADD_USER, frame_at(5), 1'b0);     // reserved count refused
    frame_cmd(CMD_FREE, frame_at(5), 1'b0);
    frame_cmd(CMD_ADD_USER, frame_at(5), 1'b0);     // one below reserved refused
    frame_cmd(CMD_SET_COW, frame_at(5), 1'b1);
    frame_cmd(CMD_RESERVE, frame_at(5), 1'b1);      // overwrite clears cow
    frame_cmd(CMD_QUERY, 32'h0000_0801, 1'b0);      // misaligned
    frame_cmd(CMD_QUERY, frame_at(MAX_FRAMES), 1'b0);  // past the last frame
    frame_cmd(CMD_INVALID, frame_at(3), 1'b1);
    contig_cmd('0, '1, 5'd0);                       // empty run
    contig_cmd(3 * PAGE + 1, '1, 5'd14);            // rounds up to four frames
    contig_cmd(PAGE, '0, 5'd0);                     // limit below everything
    contig_cmd(PAGE, '1, 5'd31);                    // no aligned start left

    // sender light, receiver heavy
    run_phase(32'h0000_0000, 64, 300, 19, 56, 1'b1);
    run_phase(32'hFFFF_F000, 1, 60, 19, 56, 1'b0);   // wraps the address space
    run_phase(32'h0000_0000, 0, 30, 19, 56, 1'b0);   // nothing managed
    // sender heavy, receiver light
    run_phase($urandom & ~32'(PAGE - 1), 100, 300, 56, 19, 1'b1);
    run_phase(32'hFFFF_FFFF, 48, 100, 56, 19, 1'b0);
    // no idling at all
    run_phase($urandom, $urandom_range(200, 2), 200, 0, 0, 1'b0);
    run_phase($urandom & ~32'(PAGE - 1), MAX_FRAMES, 25, 0, 0, 1'b0);
    run_phase(32'h0000_0000, (1 << FC_W) - 1, 25, 0, 0, 1'b0);  // clamps to full table
    run_phase($urandom & ~32'(PAGE - 1), 32, 160, 0, 0, 1'b1);

    drain_results();
    if (mismatch_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/rpfa_pkg.sv
design/refcounted_page_frame_allocator.sv
test/rpfa_frame_checker.sv
test/refcounted_page_frame_allocator_tb.sv
